// File: hw/rtl/eprc_pkg.sv
// Package for the EEPROM page register controller.
// Holds the array geometry, bus access codes and the controller/datapath structs.
// No dependencies.
`default_nettype none

package eprc_pkg;

    // Array geometry: 64 pages of 64 bytes, held as 32-bit words
    localparam int PAGE_BYTES = 64;
    localparam int PAGE_COUNT = 64;
    localparam int OFFS_W     = $clog2(PAGE_BYTES);
    localparam int PAGE_W     = $clog2(PAGE_COUNT);
    localparam int PAGE_WORDS = PAGE_BYTES / 4;
    localparam int WORD_W     = $clog2(PAGE_WORDS);
    localparam int ARR_AW     = PAGE_W + WORD_W;
    localparam int DATA_W     = 32;

    // Bus access codes
    localparam logic [2:0] OPC_SET_ADDR    = 3'd0;
    localparam logic [2:0] OPC_SET_CMD     = 3'd1;
    localparam logic [2:0] OPC_WRITE_DATA  = 3'd2;
    localparam logic [2:0] OPC_READ_DATA   = 3'd3;
    localparam logic [2:0] OPC_READ_STATUS = 3'd4;
    localparam logic [2:0] OPC_CLR_STATUS  = 3'd5;

    // Command field codes
    localparam logic [1:0] WID_8         = 2'd0;
    localparam logic [1:0] WID_16        = 2'd1;
    localparam logic [1:0] OP_ERASE_PROG = 2'd2;

    // Status bits
    localparam int STAT_ACCESS_DONE = 0;
    localparam int STAT_PROG_DONE   = 1;

    typedef struct packed {
        logic latch;       // take the accepted item into the datapath
        logic exec;        // apply the item to the register state
        logic prog_step;   // copy one buffer word into the array
        logic rd_capture;  // take array read data into the result
        logic load;        // move the result into the output register
    } eprc_cmd_t;

    typedef struct packed {
        logic need_prog;
        logic need_read;
        logic prog_last;
        logic out_free;
    } eprc_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/eprc_ctrl.sv
// Controller state machine for the EEPROM page register controller.
// Sequences accept, execute, page copy, array read and result hand-off.
// Depends on eprc_pkg.
`default_nettype none

module eprc_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  eprc_pkg::eprc_stat_t stat,
    output eprc_pkg::eprc_cmd_t  cmd
);
    import eprc_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_PROG = 3'd2;
    localparam logic [2:0] ST_READ = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                priority if (stat.need_prog) begin
                    state_next = ST_PROG;
                end else if (stat.need_read) begin
                    state_next = ST_READ;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_PROG: begin
                cmd.prog_step = 1'b1;
                if (stat.prog_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_READ: begin
                cmd.rd_capture = 1'b1;
                state_next     = ST_DONE;
            end
            ST_DONE: begin
                // hold the result until the output register frees up
                if (stat.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/eprc_datapath.sv
// Datapath for the EEPROM page register controller: address and command
// registers, page buffer, word array with page valid bits, output register.
// Depends on eprc_pkg; driven by eprc_ctrl commands.
`default_nettype none

module eprc_datapath (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  eprc_pkg::eprc_cmd_t   cmd,
    output eprc_pkg::eprc_stat_t  stat,
    input  wire  [2:0]            s_opcode,
    input  wire  [31:0]           s_bus_wdata,
    output logic                  m_valid,
    input  wire                   m_ready,
    output logic [31:0]           m_read_value,
    output logic [1:0]            m_done_flags,
    output logic                  m_access_error
);
    import eprc_pkg::*;

    logic [2:0]        in_op_reg;
    logic [DATA_W-1:0] in_data_reg;
    logic [PAGE_W-1:0] page_reg,   page_next;
    logic [OFFS_W-1:0] offset_reg, offset_next;
    logic [1:0]        width_reg,  width_next;
    logic [1:0]        status_reg, status_next;
    logic [DATA_W-1:0] rv_reg,     rv_next;
    logic              err_reg,    err_next;
    logic [WORD_W-1:0] cnt_reg;
    logic              m_valid_reg;
    logic [DATA_W-1:0] m_value_reg;
    logic [1:0]        m_flags_reg;
    logic              m_err_reg;

    logic [DATA_W-1:0] buf_mem [PAGE_WORDS];
    logic [DATA_W-1:0] arr_mem [2**ARR_AW];
    logic [DATA_W-1:0] arr_rdata_reg;
    logic [PAGE_COUNT-1:0] page_valid_reg;

    logic              misal;
    logic [OFFS_W-1:0] step_bytes;
    logic [4:0]        lane_shift;
    logic [3:0]        byte_en;
    logic [DATA_W-1:0] wr_shifted;
    logic [DATA_W-1:0] rd_shifted;
    logic [DATA_W-1:0] rd_masked;
    logic              buf_we;
    logic              arr_re;
    logic [ARR_AW-1:0] arr_addr;

    always_comb begin
        unique case (width_reg)
            WID_8:   misal = 1'b0;
            WID_16:  misal = offset_reg[0];
            default: misal = (offset_reg[1:0] != 2'b00);
        endcase
    end

    assign lane_shift = {offset_reg[1:0], 3'b000};
    assign wr_shifted = in_data_reg << lane_shift;
    assign rd_shifted = arr_rdata_reg >> lane_shift;

    always_comb begin
        unique case (width_reg)
            WID_8: begin
                step_bytes = OFFS_W'(1);
                byte_en    = 4'b0001 << offset_reg[1:0];
                rd_masked  = {24'd0, rd_shifted[7:0]};
            end
            WID_16: begin
                step_bytes = OFFS_W'(2);
                byte_en    = 4'b0011 << offset_reg[1:0];
                rd_masked  = {16'd0, rd_shifted[15:0]};
            end
            default: begin
                step_bytes = OFFS_W'(4);
                byte_en    = 4'b1111;
                rd_masked  = rd_shifted;
            end
        endcase
    end

    assign stat.need_prog = (in_op_reg == OPC_SET_CMD) && (in_data_reg[3:2] == OP_ERASE_PROG);
    assign stat.need_read = (in_op_reg == OPC_READ_DATA) && !misal;
    assign stat.prog_last = (cnt_reg == WORD_W'(PAGE_WORDS - 1));
    assign stat.out_free  = !m_valid_reg || m_ready;

    assign buf_we   = cmd.exec && (in_op_reg == OPC_WRITE_DATA) && !misal;
    assign arr_re   = cmd.exec && stat.need_read;
    assign arr_addr = cmd.prog_step ? {page_reg, cnt_reg}
                                    : {page_reg, offset_reg[OFFS_W-1:2]};

    always_comb begin
        page_next   = page_reg;
        offset_next = offset_reg;
        width_next  = width_reg;
        status_next = status_reg;
        rv_next     = rv_reg;
        err_next    = err_reg;
        if (cmd.exec) begin
            rv_next  = '0;
            err_next = 1'b0;
            unique case (in_op_reg)
                OPC_SET_ADDR: begin
                    offset_next = in_data_reg[OFFS_W-1:0];
                    page_next   = in_data_reg[OFFS_W +: PAGE_W];
                end
                OPC_SET_CMD: begin
                    width_next = in_data_reg[1:0];
                    if (stat.need_prog) begin
                        status_next[STAT_PROG_DONE] = 1'b1;
                    end
                end
                OPC_WRITE_DATA, OPC_READ_DATA: begin
                    if (misal) begin
                        err_next = 1'b1;
                    end else begin
                        status_next[STAT_ACCESS_DONE] = 1'b1;
                        // reads advance the offset once the data is taken
                        if (in_op_reg == OPC_WRITE_DATA) begin
                            offset_next = offset_reg + step_bytes;
                        end
                    end
                end
                OPC_READ_STATUS: begin
                    rv_next = {30'd0, status_reg};
                end
                OPC_CLR_STATUS: begin
                    status_next = status_reg & ~in_data_reg[1:0];
                end
                default: begin
                end
            endcase
        end
        if (cmd.rd_capture) begin
            rv_next     = page_valid_reg[page_reg] ? rd_masked : '0;
            offset_next = offset_reg + step_bytes;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_reg    <= '0;
            offset_reg  <= '0;
            width_reg   <= WID_8;
            status_reg  <= '0;
            m_valid_reg <= 1'b0;
            page_valid_reg <= '0;
        end else begin
            page_reg   <= page_next;
            offset_reg <= offset_next;
            width_reg  <= width_next;
            status_reg <= status_next;
            if (cmd.load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.prog_step && stat.prog_last) begin
                page_valid_reg[page_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rv_reg  <= rv_next;
        err_reg <= err_next;
        if (cmd.latch) begin
            in_op_reg   <= s_opcode;
            in_data_reg <= s_bus_wdata;
        end
        if (cmd.latch) begin
            cnt_reg <= '0;
        end else if (cmd.prog_step) begin
            cnt_reg <= cnt_reg + WORD_W'(1);
        end
        if (cmd.load) begin
            m_value_reg <= rv_reg;
            m_flags_reg <= status_reg;
            m_err_reg   <= err_reg;
        end
    end

    // Page buffer, cleared by reset, written per byte lane
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PAGE_WORDS; i++) begin
                buf_mem[i] <= '0;
            end
        end else if (buf_we) begin
            for (int b = 0; b < 4; b++) begin
                if (byte_en[b]) begin
                    buf_mem[offset_reg[OFFS_W-1:2]][8*b +: 8] <= wr_shifted[8*b +: 8];
                end
            end
        end
    end

    // Word array; a page reads as zero until it has been programmed
    always_ff @(posedge aclk) begin
        if (cmd.prog_step) begin
            arr_mem[arr_addr] <= buf_mem[cnt_reg];
        end
        if (arr_re) begin
            arr_rdata_reg <= arr_mem[arr_addr];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_read_value   = m_value_reg;
    assign m_done_flags   = m_flags_reg;
    assign m_access_error = m_err_reg;

endmodule

`default_nettype wire

// File: hw/rtl/eeprom_page_register_controller_unit.sv
// Top level of the EEPROM page register controller.
// One bus access per item: accept, execute, then done; an array read adds a read state
// (registered array port), erase-program a page copy (one buffer word copied per cycle).
// The next item is taken once the result is in the output register. Synchronous active-low
// reset clears the state, address, command and status registers, the output valid flag,
// the page buffer and the page valid bits; no clearing pass is needed.
`default_nettype none

module eeprom_page_register_controller_unit (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [2:0]  s_opcode,
    input  wire  [31:0] s_bus_wdata,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [31:0] m_read_value,
    output logic [1:0]  m_done_flags,
    output logic        m_access_error
);
    import eprc_pkg::*;

    eprc_cmd_t  cmd;
    eprc_stat_t stat;

    eprc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    eprc_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_opcode       (s_opcode),
        .s_bus_wdata    (s_bus_wdata),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_read_value   (m_read_value),
        .m_done_flags   (m_done_flags),
        .m_access_error (m_access_error)
    );

endmodule

`default_nettype wire

// File: hw/rtl/eprc_checker.sv
// Port-level checks for the EEPROM page register controller, with the bind
// that attaches them to the top level. Depends on the top-level port list only.
`default_nettype none

module eprc_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_valid,
    input wire        s_ready,
    input wire [2:0]  s_opcode,
    input wire [31:0] s_bus_wdata,
    input wire        m_valid,
    input wire        m_ready,
    input wire [31:0] m_read_value,
    input wire [1:0]  m_done_flags,
    input wire        m_access_error
);

    // one item at a time: an accept closes the input until the result is out
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted twice in a row");

    // an offered item waits unchanged until it is taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && !s_ready) |=> (s_valid && $stable(s_opcode) && $stable(s_bus_wdata)))
        else $error("waiting input item changed");

    // a refused access returns no data
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_access_error) |-> (m_read_value == 32'd0))
        else $error("refused access carries data");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_read_value)
                                   && $stable(m_done_flags) && $stable(m_access_error)))
        else $error("stalled result changed");

endmodule

bind eeprom_page_register_controller_unit eprc_checker u_eprc_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_opcode       (s_opcode),
    .s_bus_wdata    (s_bus_wdata),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_read_value   (m_read_value),
    .m_done_flags   (m_done_flags),
    .m_access_error (m_access_error)
);

`default_nettype wire

// File: tb/eeprom_page_register_controller_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for eeprom_page_register_controller_unit: drives bus accesses with random idling,
// predicts every response from a shadow copy of the array and page buffer, and checks it.
// Depends on eprc_pkg and the controller top level.

module eeprom_page_register_controller_unit_tb;
    import eprc_pkg::*;

    localparam logic [1:0] WID_32      = 2'd2;
    localparam logic [1:0] WID_RSVD    = 2'd3;
    localparam logic [1:0] OP_READ     = 2'd0;
    localparam logic [1:0] OP_WRITE    = 2'd1;
    localparam logic [1:0] OP_RSVD     = 2'd3;
    localparam logic [2:0] OPC_SPARE_6 = 3'd6;
    localparam logic [2:0] OPC_SPARE_7 = 3'd7;

    localparam int RESET_CYCLES    = 12;
    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 40;
    localparam int ITEM_TARGET     = 850;

    typedef struct {
        logic [31:0] read_value;
        logic [1:0]  done_flags;
        logic        access_error;
    } bus_response_t;

    class eeprom_access_checker;
        bit [7:0]        array_bytes [PAGE_BYTES*PAGE_COUNT];
        bit [7:0]        buffer_bytes [PAGE_BYTES];
        bit [PAGE_W-1:0] cur_page;
        bit [OFFS_W-1:0] cur_offset;
        bit [1:0]        cur_width;
        bit [1:0]        cur_op;
        bit [1:0]        status;
        bus_response_t   pending_responses[$];
        int mismatches;
        int accesses;
        int responses;
        int programs;
        int refusals;

        function int access_bytes();
            case (cur_width)
                WID_8:   return 1;
                WID_16:  return 2;
                default: return 4;
            endcase
        endfunction

        function bit misaligned();
            case (cur_width)
                WID_8:   return 1'b0;
                WID_16:  return cur_offset[0];
                default: return cur_offset[1:0] != 2'd0;
            endcase
        endfunction

        function void take_access(logic [2:0] opc, logic [31:0] wd);
            bus_response_t   rsp;
            int              k;
            int              nb;
            bit [OFFS_W-1:0] pos;
            rsp.read_value   = '0;
            rsp.access_error = 1'b0;
            case (opc)
                OPC_SET_ADDR: begin
                    cur_offset = wd[OFFS_W-1:0];
                    cur_page   = wd[OFFS_W +: PAGE_W];
                end
                OPC_SET_CMD: begin
                    cur_width = wd[1:0];
                    cur_op    = wd[3:2];
                    if (cur_op == OP_ERASE_PROG) begin
                        for (k = 0; k < PAGE_BYTES; k++)
                            array_bytes[int'(cur_page) * PAGE_BYTES + k] = buffer_bytes[k];
                        status[STAT_PROG_DONE] = 1'b1;
                        programs++;
                    end
                end
                OPC_WRITE_DATA, OPC_READ_DATA: begin
                    if (misaligned()) begin
                        rsp.access_error = 1'b1;
                        refusals++;
                    end else begin
                        nb = access_bytes();
                        for (k = 0; k < nb; k++) begin
                            // byte addresses wrap within the page
                            pos = cur_offset + OFFS_W'(k);
                            if (opc == OPC_WRITE_DATA)
                                buffer_bytes[pos] = wd[8*k +: 8];
                            else
                                rsp.read_value[8*k +: 8] =
                                    array_bytes[int'(cur_page) * PAGE_BYTES + int'(pos)];
                        end
                        cur_offset = cur_offset + OFFS_W'(nb);
                        status[STAT_ACCESS_DONE] = 1'b1;
                    end
                end
                OPC_READ_STATUS: rsp.read_value = {30'd0, status};
                OPC_CLR_STATUS:  status = status & ~wd[1:0];
                default: ;
            endcase
            rsp.done_flags = status;
            pending_responses.push_back(rsp);
            accesses++;
        endfunction

        task flag_mismatch(string msg);
            mismatches++;
            $display("[%0t] mismatch on response %0d: %s", $time, responses, msg);
        endtask

        task check_response(logic [31:0] rv, logic [1:0] df, logic err);
            bus_response_t want;
            responses++;
            if (pending_responses.size() == 0) begin
                flag_mismatch($sformatf("response with no access outstanding (value %h)", rv));
            end else begin
                want = pending_responses.pop_front();
                if (rv !== want.read_value)
                    flag_mismatch($sformatf("read_value %h, want %h", rv, want.read_value));
                if (df !== want.done_flags)
                    flag_mismatch($sformatf("done_flags %b, want %b", df, want.done_flags));
                if (err !== want.access_error)
                    flag_mismatch($sformatf("access_error %b, want %b",
                                            err, want.access_error));
            end
        endtask

        task check_drained();
            if (pending_responses.size() != 0)
                flag_mismatch($sformatf("%0d responses never arrived",
                                        pending_responses.size()));
        endtask
    endclass

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic [2:0]  s_opcode    = '0;
    logic [31:0] s_bus_wdata = '0;
    logic        m_ready     = 1'b0;
    wire         s_ready;
    wire         m_valid;
    wire  [31:0] m_read_value;
    wire  [1:0]  m_done_flags;
    wire         m_access_error;

    bit gaps_on      = 1'b1;
    bit hold_off_req = 1'b0;
    int sent_items   = 0;

    eeprom_access_checker chk;

    eeprom_page_register_controller_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_bus_wdata    (s_bus_wdata),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_read_value   (m_read_value),
        .m_done_flags   (m_done_flags),
        .m_access_error (m_access_error)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                chk.take_access(s_opcode, s_bus_wdata);
            if (m_valid && m_ready)
                chk.check_response(m_read_value, m_done_flags, m_access_error);
        end
    end

    // result side: random ready bursts, or one long hold-off on request
    initial begin : receiver
        int span;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                hold_off_req = 1'b0;
            end else begin
                span = $urandom_range(1, 8);
                m_ready <= !gaps_on || $urandom_range(0, 2) != 0;
                repeat (span - 1) @(negedge aclk);
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        @(posedge aresetn);
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("No handshake for %0d cycles, giving up", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [31:0] cmd_word(logic [1:0] width, logic [1:0] op);
        logic [31:0] w;
        w      = $urandom;
        w[3:2] = op;
        w[1:0] = width;
        return w;
    endfunction

    function automatic logic [31:0] addr_word(logic [PAGE_W-1:0] page,
                                              logic [OFFS_W-1:0] offset);
        logic [31:0] w;
        w                   = $urandom;
        w[OFFS_W-1:0]       = offset;
        w[OFFS_W +: PAGE_W] = page;
        return w;
    endfunction

    // mostly aligned to the width, now and then at any offset
    function automatic logic [OFFS_W-1:0] pick_offset(logic [1:0] width);
        logic [OFFS_W-1:0] off;
        off = OFFS_W'($urandom_range(0, PAGE_BYTES - 1));
        if ($urandom_range(0, 7) != 0) begin
            if (width == WID_16)
                off[0] = 1'b0;
            else if (width != WID_8)
                off[1:0] = 2'b00;
        end
        return off;
    endfunction

    // starts and ends at a falling edge; valid stays up when the next item follows at once
    task automatic send_access(input logic [2:0] opc, input logic [31:0] wd);
        s_valid     <= 1'b1;
        s_opcode    <= opc;
        s_bus_wdata <= wd;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (opc <= OPC_CLR_STATUS)
            sent_items++;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
    endtask

    task automatic drain_pending();
        s_valid <= 1'b0;
        while (chk.pending_responses.size() != 0) @(negedge aclk);
        @(negedge aclk);
    endtask

    task automatic run_directed();
        send_access(OPC_READ_STATUS, 32'd0);
        send_access(OPC_SET_CMD, cmd_word(WID_8, OP_WRITE));
        send_access(OPC_WRITE_DATA, 32'hFFFF_FFA5);            // low byte only
        send_access(OPC_SET_CMD, cmd_word(WID_16, OP_WRITE));
        send_access(OPC_WRITE_DATA, 32'h0000_5A5A);            // odd offset, refused
        send_access(OPC_SET_ADDR, addr_word(6'd0, 6'd62));
        send_access(OPC_WRITE_DATA, 32'h1234_BEEF);            // wraps to offset 0
        send_access(OPC_SET_ADDR, 32'hFFFF_FFFF);
        send_access(OPC_SET_CMD, cmd_word(WID_32, OP_WRITE));
        send_access(OPC_WRITE_DATA, 32'hFFFF_FFFF);            // offset 63, refused
        send_access(OPC_SET_ADDR, addr_word(6'd63, 6'd4));
        send_access(OPC_WRITE_DATA, 32'hDEAD_BEEF);
        send_access(OPC_SET_CMD, cmd_word(WID_RSVD, OP_RSVD)); // width three acts as 32 bit
        send_access(OPC_WRITE_DATA, 32'h0000_0000);
        send_access(OPC_SET_CMD, cmd_word(WID_8, OP_ERASE_PROG));
        send_access(OPC_READ_STATUS, 32'hFFFF_FFFF);
        send_access(OPC_SET_CMD, cmd_word(WID_32, OP_READ));
        send_access(OPC_SET_ADDR, addr_word(6'd63, 6'd60));
        send_access(OPC_READ_DATA, 32'd0);
        send_access(OPC_READ_DATA, 32'hFFFF_FFFF);
        send_access(OPC_SET_CMD, cmd_word(WID_16, OP_READ));
        send_access(OPC_SET_ADDR, addr_word(6'd63, 6'd5));
        send_access(OPC_READ_DATA, 32'd0);                     // refused
        send_access(OPC_SPARE_6, 32'hFFFF_FFFF);
        send_access(OPC_SPARE_7, 32'hFFFF_FFFF);
        send_access(OPC_CLR_STATUS, 32'hFFFF_FFFE);            // drop program done only
        send_access(OPC_READ_STATUS, 32'd0);
        send_access(OPC_CLR_STATUS, 32'hFFFF_FFFF);
    endtask

    // fill and program pages, read them back, with some raw accesses in between
    task automatic run_random(int stop_at);
        int                pick;
        logic [1:0]        width;
        logic [PAGE_W-1:0] page;
        while (sent_items < stop_at) begin
            pick  = $urandom_range(0, 99);
            width = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 3) == 0)
                page = PAGE_W'($urandom_range(0, PAGE_COUNT - 1));
            else
                page = PAGE_W'($urandom_range(0, 7));
            if (pick < 40) begin
                send_access(OPC_SET_ADDR, addr_word(page, pick_offset(width)));
                send_access(OPC_SET_CMD, cmd_word(width, OP_WRITE));
                repeat ($urandom_range(1, 20)) send_access(OPC_WRITE_DATA, $urandom);
                send_access(OPC_SET_CMD, cmd_word(2'($urandom_range(0, 3)), OP_ERASE_PROG));
                if ($urandom_range(0, 1) == 1)
                    send_access(OPC_READ_STATUS, $urandom);
                if ($urandom_range(0, 1) == 1)
                    send_access(OPC_CLR_STATUS, $urandom);
            end else if (pick < 75) begin
                send_access(OPC_SET_ADDR, addr_word(page, pick_offset(width)));
                send_access(OPC_SET_CMD, cmd_word(width, OP_READ));
                repeat ($urandom_range(1, 20)) send_access(OPC_READ_DATA, $urandom);
                if ($urandom_range(0, 1) == 1)
                    send_access(OPC_READ_STATUS, $urandom);
            end else begin
                send_access(3'($urandom_range(0, 7)), $urandom);
            end
        end
    endtask

    initial begin : stimulus
        chk = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        run_directed();
        run_random(300);

        // hold off the result side while items keep coming
        gaps_on      = 1'b0;
        hold_off_req = 1'b1;
        run_random(sent_items + 30);
        gaps_on = 1'b1;

        drain_pending();
        run_random(650);

        gaps_on = 1'b0;
        run_random(ITEM_TARGET);
        drain_pending();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        chk.check_drained();

        $display("Checked %0d responses to %0d accesses: %0d page programs, %0d refused.",
                 chk.responses, chk.accesses, chk.programs, chk.refusals);
        $display("Covered corner accesses, random fill/program/readback, a %0d-cycle stall.",
                 HOLD_OFF_CYCLES);
        if (chk.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
